### rtl/point_segment_distance_assert.svh
// Assertion macros used by the point to segment distance RTL
`ifndef POINT_SEGMENT_DISTANCE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_ASSERT_SVH

`ifndef SYNTH
`define PSD_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psd assertion failed");
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psd assertion failed");
`else
`define PSD_ASSERT_IMPLIES(lbl, ante, cons)
`define PSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/psd_pkg.sv
// Shared types and constants of the point to segment distance block
package psd_pkg;

    localparam int MIN_LEN_W = 17;
    localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 17'd7;

    typedef enum logic [1:0] {
        PART_DEGEN    = 2'd0,
        PART_START    = 2'd1,
        PART_END      = 2'd2,
        PART_INTERIOR = 2'd3
    } part_t;

    typedef struct packed {
        logic valid;
        logic dot_pos;
        logic dot_ge;
    } sqrt_ctl_t;

    typedef struct packed {
        logic  valid;
        part_t part;
    } div_ctl_t;

endpackage

### rtl/psd_sqrt_cell.sv
// One root bit of three integer square roots, with the side data handed along
module psd_sqrt_cell #(
    parameter int RW = 34,
    parameter int XW = 67
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  psd_pkg::sqrt_ctl_t         ctl_in,
    input  logic [2:0][2*RW-1:0]       rad_in,
    input  logic [2:0][RW+1:0]         rem_in,
    input  logic [2:0][RW-1:0]         root_in,
    input  logic [XW-1:0]              cross_in,
    output psd_pkg::sqrt_ctl_t         ctl_out,
    output logic [2:0][2*RW-1:0]       rad_out,
    output logic [2:0][RW+1:0]         rem_out,
    output logic [2:0][RW-1:0]         root_out,
    output logic [XW-1:0]              cross_out
);

    psd_pkg::sqrt_ctl_t   ctl_reg;
    logic [2:0][2*RW-1:0] rad_reg, rad_next;
    logic [2:0][RW+1:0]   rem_reg, rem_next;
    logic [2:0][RW-1:0]   root_reg, root_next;
    logic [XW-1:0]        cross_reg;

    always_comb
    begin
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;
        for (int k = 0; k < 3; k++)
        begin
            r2    = {rem_in[k][RW-1:0], rad_in[k][2*RW-1 -: 2]};
            trial = {root_in[k], 2'b01};
            if (r2 >= trial)
            begin
                rem_next[k]  = r2 - trial;
                root_next[k] = {root_in[k][RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = r2;
                root_next[k] = {root_in[k][RW-2:0], 1'b0};
            end
            rad_next[k] = {rad_in[k][2*RW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg   <= rad_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            cross_reg <= cross_in;
        end
    end

    assign ctl_out   = ctl_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign cross_out = cross_reg;

endmodule

### rtl/psd_div_cell.sv
// One quotient bit of a restoring divide, with the result data handed along
module psd_div_cell #(
    parameter int RW = 34,
    parameter int QW = 35,
    parameter int OW = 33
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  psd_pkg::div_ctl_t   ctl_in,
    input  logic [QW-1:0]       num_in,
    input  logic [QW-1:0]       quo_in,
    input  logic [RW-1:0]       rem_in,
    input  logic [RW-1:0]       len_in,
    input  logic [OW-1:0]       dist_in,
    output psd_pkg::div_ctl_t   ctl_out,
    output logic [QW-1:0]       num_out,
    output logic [QW-1:0]       quo_out,
    output logic [RW-1:0]       rem_out,
    output logic [RW-1:0]       len_out,
    output logic [OW-1:0]       dist_out
);

    psd_pkg::div_ctl_t ctl_reg;
    logic [QW-1:0]     num_reg, quo_reg, quo_next;
    logic [RW-1:0]     rem_reg, rem_next, len_reg;
    logic [OW-1:0]     dist_reg;
    logic [RW:0]       r2, diff;
    logic              ge;

    assign r2   = {rem_in, num_in[QW-1]};
    assign diff = r2 - {1'b0, len_in};
    assign ge   = (r2 >= {1'b0, len_in});
    assign rem_next = ge ? diff[RW-1:0] : r2[RW-1:0];
    assign quo_next = {quo_in[QW-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= {num_in[QW-2:0], 1'b0};
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            len_reg  <= len_in;
            dist_reg <= dist_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign num_out  = num_reg;
    assign quo_out  = quo_reg;
    assign rem_out  = rem_reg;
    assign len_out  = len_reg;
    assign dist_out = dist_reg;

endmodule

### rtl/point_segment_distance.sv
// Throughput: one beat per cycle; all stages advance together unless the output stalls.
// Three arithmetic stages, then one cell per root bit of the square roots (COORD_WIDTH+2),
// one select stage, one cell per quotient bit of the divide (COORD_WIDTH+3), output register.
// Reset: pipeline valid bits clear, min_length returns to 7.
`include "point_segment_distance_assert.svh"
module point_segment_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [COORD_WIDTH:0]         seg_distance,
    output logic [1:0]                   nearest_part
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int RW   = CW + 2;
    localparam int QW   = CW + 3;
    localparam int OW   = CW + 1;
    localparam int MLW  = psd_pkg::MIN_LEN_W;
    localparam int CMPW = (RW > MLW) ? RW : MLW;

    logic out_valid_reg;
    logic adv;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration
    logic [MLW-1:0] min_length_reg;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(min_length_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= psd_pkg::MIN_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            min_length_reg <= pwdata[MLW-1:0];
        end
    end

    // stage A: differences
    logic a_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, tx_reg, ty_reg, ux_reg, uy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg <= DW'(end_x) - DW'(start_x);
            dy_reg <= DW'(end_y) - DW'(start_y);
            tx_reg <= DW'(point_x) - DW'(start_x);
            ty_reg <= DW'(point_y) - DW'(start_y);
            ux_reg <= DW'(point_x) - DW'(end_x);
            uy_reg <= DW'(point_y) - DW'(end_y);
        end
    end

    // stage B: products
    logic b_valid_reg;
    logic signed [PW-1:0] dxx_reg, dyy_reg, txdx_reg, tydy_reg, txdy_reg, tydx_reg;
    logic signed [PW-1:0] txx_reg, tyy_reg, uxx_reg, uyy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxx_reg  <= PW'(dx_reg) * PW'(dx_reg);
            dyy_reg  <= PW'(dy_reg) * PW'(dy_reg);
            txdx_reg <= PW'(tx_reg) * PW'(dx_reg);
            tydy_reg <= PW'(ty_reg) * PW'(dy_reg);
            txdy_reg <= PW'(tx_reg) * PW'(dy_reg);
            tydx_reg <= PW'(ty_reg) * PW'(dx_reg);
            txx_reg  <= PW'(tx_reg) * PW'(tx_reg);
            tyy_reg  <= PW'(ty_reg) * PW'(ty_reg);
            uxx_reg  <= PW'(ux_reg) * PW'(ux_reg);
            uyy_reg  <= PW'(uy_reg) * PW'(uy_reg);
        end
    end

    // stage C: sums and projection tests
    logic signed [SW-1:0] dd_c, dot_c, cross_c, ss_c, ee_c;
    logic                 c_valid_reg, dot_pos_reg, dot_ge_reg;
    logic [SW-1:0]        dd_reg, ss_reg, ee_reg, cross_abs_reg;

    assign dd_c    = SW'(dxx_reg) + SW'(dyy_reg);
    assign dot_c   = SW'(txdx_reg) + SW'(tydy_reg);
    assign cross_c = SW'(txdy_reg) - SW'(tydx_reg);
    assign ss_c    = SW'(txx_reg) + SW'(tyy_reg);
    assign ee_c    = SW'(uxx_reg) + SW'(uyy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_reg        <= dd_c;
            ss_reg        <= ss_c;
            ee_reg        <= ee_c;
            dot_pos_reg   <= !dot_c[SW-1] && (dot_c != '0);
            dot_ge_reg    <= (dot_c >= dd_c);
            cross_abs_reg <= cross_c[SW-1] ? SW'(-cross_c) : cross_c;
        end
    end

    // square root cells
    psd_pkg::sqrt_ctl_t   sq_ctl   [0:RW];
    logic [2:0][2*RW-1:0] sq_rad   [0:RW];
    logic [2:0][RW+1:0]   sq_rem   [0:RW];
    logic [2:0][RW-1:0]   sq_root  [0:RW];
    logic [SW-1:0]        sq_cross [0:RW];

    assign sq_ctl[0]   = '{valid: c_valid_reg, dot_pos: dot_pos_reg, dot_ge: dot_ge_reg};
    assign sq_rad[0]   = {{1'b0, ee_reg}, {1'b0, ss_reg}, {1'b0, dd_reg}};
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_cross[0] = cross_abs_reg;

    for (genvar i = 0; i < RW; i++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .RW (RW),
            .XW (SW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .ctl_in    (sq_ctl[i]),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .cross_in  (sq_cross[i]),
            .ctl_out   (sq_ctl[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .cross_out (sq_cross[i+1])
        );
    end

    // select stage
    psd_pkg::part_t part_next;
    logic [RW-1:0]  len_fin, ds_fin, de_fin, dsel;
    logic [OW-1:0]  dist_next;

    assign len_fin = sq_root[RW][0];
    assign ds_fin  = sq_root[RW][1];
    assign de_fin  = sq_root[RW][2];

    always_comb
    begin
        if (CMPW'(len_fin) < CMPW'(min_length_reg))
        begin
            part_next = psd_pkg::PART_DEGEN;
        end
        else if (!sq_ctl[RW].dot_pos)
        begin
            part_next = psd_pkg::PART_START;
        end
        else if (sq_ctl[RW].dot_ge)
        begin
            part_next = psd_pkg::PART_END;
        end
        else
        begin
            part_next = psd_pkg::PART_INTERIOR;
        end
    end

    assign dsel      = (part_next == psd_pkg::PART_END) ? de_fin : ds_fin;
    assign dist_next = dsel[RW-1] ? {OW{1'b1}} : dsel[OW-1:0];

    logic           dc_valid_reg;
    psd_pkg::part_t dc_part_reg;
    logic [RW-1:0]  dc_len_reg, dc_rem_reg;
    logic [QW-1:0]  dc_num_reg;
    logic [OW-1:0]  dc_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dc_valid_reg <= sq_ctl[RW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dc_part_reg <= part_next;
            dc_len_reg  <= len_fin;
            dc_rem_reg  <= RW'(sq_cross[RW][SW-1:QW]);
            dc_num_reg  <= sq_cross[RW][QW-1:0];
            dc_dist_reg <= dist_next;
        end
    end

    // divide cells
    psd_pkg::div_ctl_t dv_ctl  [0:QW];
    logic [QW-1:0]     dv_num  [0:QW];
    logic [QW-1:0]     dv_quo  [0:QW];
    logic [RW-1:0]     dv_rem  [0:QW];
    logic [RW-1:0]     dv_len  [0:QW];
    logic [OW-1:0]     dv_dist [0:QW];

    assign dv_ctl[0]  = '{valid: dc_valid_reg, part: dc_part_reg};
    assign dv_num[0]  = dc_num_reg;
    assign dv_quo[0]  = '0;
    assign dv_rem[0]  = dc_rem_reg;
    assign dv_len[0]  = dc_len_reg;
    assign dv_dist[0] = dc_dist_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        psd_div_cell #(
            .RW (RW),
            .QW (QW),
            .OW (OW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .ctl_in   (dv_ctl[j]),
            .num_in   (dv_num[j]),
            .quo_in   (dv_quo[j]),
            .rem_in   (dv_rem[j]),
            .len_in   (dv_len[j]),
            .dist_in  (dv_dist[j]),
            .ctl_out  (dv_ctl[j+1]),
            .num_out  (dv_num[j+1]),
            .quo_out  (dv_quo[j+1]),
            .rem_out  (dv_rem[j+1]),
            .len_out  (dv_len[j+1]),
            .dist_out (dv_dist[j+1])
        );
    end

    // output register
    logic [OW-1:0]  out_dist_reg, quo_sat;
    psd_pkg::part_t out_part_reg;

    assign quo_sat = (dv_quo[QW][QW-1:QW-2] != 2'b00) ? {OW{1'b1}} : dv_quo[QW][OW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_ctl[QW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_part_reg <= dv_ctl[QW].part;
            out_dist_reg <= (dv_ctl[QW].part == psd_pkg::PART_INTERIOR) ? quo_sat
                                                                         : dv_dist[QW];
        end
    end

    assign out_valid    = out_valid_reg;
    assign seg_distance = out_dist_reg;
    assign nearest_part = out_part_reg;

    `PSD_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, a_valid_reg)
    `PSD_ASSERT_IMPLIES(a_interior_len, dc_valid_reg && dc_part_reg == psd_pkg::PART_INTERIOR, dc_len_reg != '0)
    `PSD_ASSERT_IMPLIES(a_end_not_degen, dc_valid_reg && dc_part_reg == psd_pkg::PART_END, CMPW'(dc_len_reg) >= CMPW'(min_length_reg))

endmodule
